[rtl/csls_pkg.sv]
package csls_pkg;

   // Result position field width (the low bits of the internal position).
   localparam int POS_OUT_BITS = 32;

   // Result queue depth; two slots must be free before a beat is taken.
   localparam int QDEPTH = 4;

   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_NONE      = 8'h00;

   // A tab moves the position on by this much; every other counted byte by one.
   localparam int TAB_ADVANCE = 8;

   typedef enum logic [1:0] {
      STATUS_CHAR       = 2'd0,
      STATUS_END        = 2'd1,
      STATUS_CR_NO_LF   = 2'd2,
      STATUS_UNEXP_END  = 2'd3
   } status_type;

   typedef struct packed {
      logic                    last;
      status_type              status;
      logic [POS_OUT_BITS-1:0] position;
      logic [7:0]              out_char;
   } result_type;

   typedef struct packed {
      logic [1:0]            count;
      result_type [1:0]      item;
   } push_type;

endpackage

[rtl/csls_step.sv]
module csls_step import csls_pkg::*; #(
   parameter int POS_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] byte_in,
   input  logic       end_mark,
   output push_type   push
);

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_BSL,
      MODE_CR,
      MODE_BSL_CR
   } mode_type;

   localparam int SUM_BITS = POS_BITS + 1;

   mode_type              mode_ff, mode_in;
   logic [POS_BITS-1:0]   next_pos_ff, next_pos_in;
   logic [POS_BITS-1:0]   held_pos_ff, held_pos_in;
   logic                  failed_ff, failed_in;

   logic [SUM_BITS-1:0]   sum_one, sum_tab;
   logic [POS_BITS-1:0]   pos_plus_one, pos_plus_tab;

   // Outcome of a byte taken in the idle mode.
   logic                  idle_emit;
   mode_type              idle_mode;
   logic [POS_BITS-1:0]   idle_next;
   logic [POS_BITS-1:0]   idle_held;

   result_type            res0, res1;
   logic [1:0]            res_count;

   // The position saturates, so a carry out of the add pins it at all ones.
   assign sum_one      = {1'b0, next_pos_ff} + SUM_BITS'(1);
   assign sum_tab      = {1'b0, next_pos_ff} + SUM_BITS'(TAB_ADVANCE);
   assign pos_plus_one = sum_one[POS_BITS] ? '1 : sum_one[POS_BITS-1:0];
   assign pos_plus_tab = sum_tab[POS_BITS] ? '1 : sum_tab[POS_BITS-1:0];

   always_comb begin
      idle_emit = 1'b1;
      idle_mode = MODE_IDLE;
      idle_next = pos_plus_one;
      idle_held = held_pos_ff;
      if (byte_in == CHAR_CR) begin
         idle_emit = 1'b0;
         idle_mode = MODE_CR;
         idle_held = next_pos_ff;
      end else if (byte_in == CHAR_BACKSLASH) begin
         idle_emit = 1'b0;
         idle_mode = MODE_BSL;
         idle_held = next_pos_ff;
      end else if (byte_in == CHAR_TAB) begin
         idle_next = pos_plus_tab;
      end
   end

   always_comb begin
      result_type slot0, slot1;
      slot0 = '0;
      slot1 = '0;
      mode_in     = mode_ff;
      next_pos_in = next_pos_ff;
      held_pos_in = held_pos_ff;
      failed_in   = failed_ff;
      res_count   = 2'd0;

      if (accept) begin
         if (end_mark) begin
            slot0.status   = STATUS_END;
            slot0.position = POS_OUT_BITS'(next_pos_ff);
            res_count      = 2'd1;
            if (!failed_ff && mode_ff != MODE_IDLE) begin
               slot1          = slot0;
               slot0.position = POS_OUT_BITS'(held_pos_ff);
               if (mode_ff == MODE_BSL) begin
                  slot0.status   = STATUS_CHAR;
                  slot0.out_char = CHAR_BACKSLASH;
               end else begin
                  slot0.status   = STATUS_UNEXP_END;
               end
               res_count = 2'd2;
            end
            mode_in     = MODE_IDLE;
            next_pos_in = '0;
            held_pos_in = '0;
            failed_in   = 1'b0;
         end else if (!failed_ff) begin
            unique case (mode_ff)
               MODE_BSL: begin
                  if (byte_in == CHAR_LF) begin
                     mode_in = MODE_IDLE;
                  end else if (byte_in == CHAR_CR) begin
                     mode_in = MODE_BSL_CR;
                  end else begin
                     // Not a splice: the held backslash goes out ahead of this byte.
                     slot0.out_char = CHAR_BACKSLASH;
                     slot0.status   = STATUS_CHAR;
                     slot0.position = POS_OUT_BITS'(held_pos_ff);
                     slot1.out_char = byte_in;
                     slot1.status   = STATUS_CHAR;
                     slot1.position = POS_OUT_BITS'(next_pos_ff);
                     res_count      = idle_emit ? 2'd2 : 2'd1;
                     mode_in        = idle_mode;
                     next_pos_in    = idle_next;
                     held_pos_in    = idle_held;
                  end
               end
               MODE_CR, MODE_BSL_CR: begin
                  next_pos_in    = pos_plus_one;
                  mode_in        = MODE_IDLE;
                  slot0.position = POS_OUT_BITS'(next_pos_ff);
                  if (byte_in == CHAR_LF) begin
                     slot0.out_char = CHAR_LF;
                     slot0.status   = STATUS_CHAR;
                     res_count      = (mode_ff == MODE_CR) ? 2'd1 : 2'd0;
                  end else begin
                     slot0.status   = STATUS_CR_NO_LF;
                     res_count      = 2'd1;
                     failed_in      = 1'b1;
                  end
               end
               MODE_IDLE: begin
                  slot0.out_char = byte_in;
                  slot0.status   = STATUS_CHAR;
                  slot0.position = POS_OUT_BITS'(next_pos_ff);
                  res_count      = idle_emit ? 2'd1 : 2'd0;
                  mode_in        = idle_mode;
                  next_pos_in    = idle_next;
                  held_pos_in    = idle_held;
               end
               default: begin
                  mode_in = MODE_IDLE;
               end
            endcase
         end
      end

      slot0.last = (res_count == 2'd1);
      slot1.last = (res_count == 2'd2);
      res0 = slot0;
      res1 = slot1;
   end

   // Packed from the top: count, then the second result, then the first.
   assign push = {res_count, res1, res0};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         next_pos_ff <= '0;
         held_pos_ff <= '0;
         failed_ff   <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         next_pos_ff <= next_pos_in;
         held_pos_ff <= held_pos_in;
         failed_ff   <= failed_in;
      end
   end

endmodule

[rtl/csls_queue.sv]
module csls_queue import csls_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   output logic       room,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_item
);

   localparam int PTR_BITS   = $clog2(QDEPTH);
   localparam int COUNT_BITS = $clog2(QDEPTH + 1);

   result_type            entry_ff [QDEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [PTR_BITS-1:0]   wr_ptr_next;
   logic                  pop;

   assign out_valid   = (count_ff != '0);
   assign out_item    = entry_ff[rd_ptr_ff];
   assign pop         = out_valid && out_ready;
   // Taken from the registered count, so room has no combinational path from out_ready.
   assign room        = (count_ff <= COUNT_BITS'(QDEPTH - 2));
   assign wr_ptr_next = wr_ptr_ff + PTR_BITS'(1);

   assign wr_ptr_in = wr_ptr_ff + PTR_BITS'(push.count);
   assign rd_ptr_in = rd_ptr_ff + PTR_BITS'(pop);
   assign count_in  = count_ff + COUNT_BITS'(push.count) - COUNT_BITS'(pop);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.item[0];
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push.item[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/c_source_line_splicer_core.sv]
// Channel   Direction  Beat contents
// req_      in         tdata[7:0] byte_in; tlast end_mark
// rsp_      out        tdata[7:0] out_char, tdata[39:8] position; tuser[1:0] status;
//                      tlast last
//
// One byte is taken per cycle while the queue has room. The state update happens
// in the cycle a beat is accepted, and its zero, one or two results enter a
// four-entry result queue. req_tready depends only on the queue fill: a beat is
// taken while two slots are free. Results appear on rsp_ from the cycle after
// their beat. Reset is synchronous and clears the splicer state and the queue.
module c_source_line_splicer_core import csls_pkg::*; #(
   parameter int POS_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_in
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] out_char, [39:8] position
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast
);

   push_type   push;
   result_type head;
   logic       room;
   logic       accept;

   assign req_tready = room;
   assign accept     = req_tvalid && room;

   csls_step #(
      .POS_BITS (POS_BITS)
   ) u_step (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .byte_in  (req_tdata),
      .end_mark (req_tlast),
      .push     (push)
   );

   csls_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (head)
   );

   assign rsp_tdata = {head.position, head.out_char};
   assign rsp_tuser = head.status;
   assign rsp_tlast = head.last;

endmodule

[tb/line_splice_checker.sv]
`timescale 1ns / 1ps

// Watches both streams of the splicer, keeps its own copy of the splicing state,
// and checks every result beat against the oldest outstanding prediction.
module line_splice_checker import csls_pkg::*; #(
   parameter int POS_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_in
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // [7:0] out_char, [39:8] position
   input  logic [1:0]  rsp_tuser,   // [1:0] status
   input  logic        rsp_tlast,
   output int          mismatches,
   output int          pending,
   output int          checked
);

   typedef enum logic [1:0] {
      SPL_IDLE         = 2'd0,
      SPL_BACKSLASH    = 2'd1,
      SPL_CR           = 2'd2,
      SPL_BACKSLASH_CR = 2'd3
   } splice_mode_type;

   splice_mode_type     mode;
   logic [POS_BITS-1:0] next_pos;
   logic [POS_BITS-1:0] held_pos;
   logic                failed;

   result_type          expected_q[$];
   result_type          burst[2];
   int                  burst_n;
   int                  fault_count  = 0;
   int                  result_count = 0;

   function automatic logic [POS_BITS-1:0] advance(input logic [POS_BITS-1:0] p,
                                                   input int unsigned k);
      logic [POS_BITS:0] sum;
      sum = {1'b0, p} + (POS_BITS+1)'(k);
      return sum[POS_BITS] ? '1 : sum[POS_BITS-1:0];
   endfunction

   task clear_splicer();
      mode     = SPL_IDLE;
      next_pos = '0;
      held_pos = '0;
      failed   = 1'b0;
   endtask

   task note(input logic [7:0] ch, input logic [POS_BITS-1:0] pos, input status_type st);
      burst[burst_n].out_char = ch;
      burst[burst_n].position = POS_OUT_BITS'(pos);
      burst[burst_n].status   = st;
      burst[burst_n].last     = 1'b0;
      burst_n++;
   endtask

   // A byte seen with nothing held: CR and backslash are held back, the rest go out.
   task plain_byte(input logic [7:0] b);
      if (b == CHAR_CR) begin
         mode     = SPL_CR;
         held_pos = next_pos;
         next_pos = advance(next_pos, 1);
      end else if (b == CHAR_BACKSLASH) begin
         mode     = SPL_BACKSLASH;
         held_pos = next_pos;
         next_pos = advance(next_pos, 1);
      end else begin
         note(b, next_pos, STATUS_CHAR);
         next_pos = advance(next_pos, (b == CHAR_TAB) ? TAB_ADVANCE : 1);
      end
   endtask

   task splice_beat(input logic [7:0] b, input logic eos);
      burst_n = 0;
      if (eos) begin
         if (!failed) begin
            if (mode == SPL_BACKSLASH) begin
               note(CHAR_BACKSLASH, held_pos, STATUS_CHAR);
            end else if (mode == SPL_CR || mode == SPL_BACKSLASH_CR) begin
               note(CHAR_NONE, held_pos, STATUS_UNEXP_END);
            end
         end
         note(CHAR_NONE, next_pos, STATUS_END);
         clear_splicer();
      end else if (!failed) begin
         case (mode)
            SPL_BACKSLASH: begin
               if (b == CHAR_LF) begin
                  mode = SPL_IDLE;
               end else if (b == CHAR_CR) begin
                  mode = SPL_BACKSLASH_CR;
               end else begin
                  note(CHAR_BACKSLASH, held_pos, STATUS_CHAR);
                  mode = SPL_IDLE;
                  plain_byte(b);
               end
            end
            SPL_CR, SPL_BACKSLASH_CR: begin
               // The LF of a spliced backslash-CR-LF is counted but not emitted.
               if (b == CHAR_LF) begin
                  if (mode == SPL_CR) note(CHAR_LF, next_pos, STATUS_CHAR);
               end else begin
                  note(CHAR_NONE, next_pos, STATUS_CR_NO_LF);
                  failed = 1'b1;
               end
               next_pos = advance(next_pos, 1);
               mode     = SPL_IDLE;
            end
            default: plain_byte(b);
         endcase
      end
      if (burst_n > 0) burst[burst_n-1].last = 1'b1;
      for (int i = 0; i < burst_n; i++) expected_q.push_back(burst[i]);
   endtask

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         clear_splicer();
         expected_q.delete();
      end else begin
         // Results appear no earlier than the cycle after their beat, so popping first is safe.
         if (rsp_tvalid && rsp_tready) begin
            got.out_char = rsp_tdata[7:0];
            got.position = rsp_tdata[39:8];
            got.status   = status_type'(rsp_tuser);
            got.last     = rsp_tlast;
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result beat: expected none, got char %h pos %0d",
                        $time, got.out_char, got.position);
               $display("%0t: unexpected result beat: status %0d last %b",
                        $time, got.status, got.last);
               fault_count++;
            end else begin
               want = expected_q.pop_front();
               result_count++;
               if (got !== want) begin
                  fault_count++;
                  if (got.out_char !== want.out_char)
                     $display("%0t: out_char expected %h, got %h",
                              $time, want.out_char, got.out_char);
                  if (got.position !== want.position)
                     $display("%0t: position expected %0d, got %0d",
                              $time, want.position, got.position);
                  if (got.status !== want.status)
                     $display("%0t: status expected %0d, got %0d",
                              $time, want.status, got.status);
                  if (got.last !== want.last)
                     $display("%0t: last expected %b, got %b", $time, want.last, got.last);
               end
            end
         end
         if (req_tvalid && req_tready) splice_beat(req_tdata, req_tlast);
      end
      mismatches <= fault_count;
      checked    <= result_count;
      pending    <= expected_q.size();
   end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import csls_pkg::*;

   localparam int   ITEM_TARGET   = 1400;
   localparam int   CALM_ITEMS    = 150;
   localparam int   CYCLE_LIMIT   = 400000;
   localparam int   DRAIN_CYCLES  = 20;
   localparam logic END_OF_STREAM = 1'b1;
   localparam logic MORE          = 1'b0;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   int mismatches;
   int pending;
   int checked;
   bit calm          = 1'b0;
   int items_sent    = 0;
   int streams_done  = 0;
   int broken_ends   = 0;
   int cycles        = 0;
   int stall_left    = 0;

   c_source_line_splicer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   line_splice_checker monitor (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .mismatches (mismatches),
      .pending    (pending),
      .checked    (checked)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding.", cycles, pending);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Receiver: back-pressure in short random bursts, none in the closing stretch.
   always @(posedge clock) begin
      if (!calm && stall_left == 0 && $urandom_range(0, 5) == 0)
         stall_left = $urandom_range(1, 7);
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Valid stays high from one beat to the next unless a gap is inserted.
   task automatic send_beat(input logic [7:0] b, input logic eos, input bit counted);
      int gap;
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 7);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eos;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (counted) items_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] any_but(input logic [7:0] excluded);
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == excluded);
      return b;
   endfunction

   // One piece of well-formed text: a character, a line ending or a splice.
   task automatic send_token();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         send_beat(any_but(CHAR_CR), MORE, 1);
      end else if (pick < 60) begin
         send_beat(8'($urandom_range(8'h20, 8'h7E)), MORE, 1);
      end else if (pick < 67) begin
         send_beat(CHAR_TAB, MORE, 1);
      end else if (pick < 77) begin
         send_beat(CHAR_CR, MORE, 1);
         send_beat(CHAR_LF, MORE, 1);
      end else if (pick < 83) begin
         send_beat(CHAR_BACKSLASH, MORE, 1);
         send_beat(CHAR_LF, MORE, 1);
      end else if (pick < 88) begin
         send_beat(CHAR_BACKSLASH, MORE, 1);
         send_beat(CHAR_CR, MORE, 1);
         send_beat(CHAR_LF, MORE, 1);
      end else if (pick < 95) begin
         send_beat(CHAR_BACKSLASH, MORE, 1);
         send_beat(any_but(CHAR_CR), MORE, 1);
      end else begin
         send_beat(CHAR_BACKSLASH, MORE, 1);
         send_beat(CHAR_BACKSLASH, MORE, 1);
      end
   endtask

   task automatic send_stream();
      int len;
      int ending;
      int junk;
      len    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 60);
      ending = $urandom_range(0, 9);
      repeat (len) send_token();
      case (ending)
         0, 1: begin
            // A CR without its LF: everything up to the end mark is ignored.
            if (ending == 1) send_beat(CHAR_BACKSLASH, MORE, 1);
            send_beat(CHAR_CR, MORE, 1);
            send_beat(any_but(CHAR_LF), MORE, 1);
            junk = $urandom_range(0, 3);
            repeat (junk) send_beat(8'($urandom_range(0, 255)), MORE, 0);
            broken_ends++;
         end
         2: send_beat(CHAR_BACKSLASH, MORE, 1);
         3: begin
            send_beat(CHAR_CR, MORE, 1);
            broken_ends++;
         end
         4: begin
            send_beat(CHAR_BACKSLASH, MORE, 1);
            send_beat(CHAR_CR, MORE, 1);
            broken_ends++;
         end
         default: ;
      endcase
      send_beat(8'($urandom_range(0, 255)), END_OF_STREAM, 1);
      streams_done++;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Extremes, line endings, both splices and a lone backslash.
      send_beat(8'h61, MORE, 1);           send_beat(8'h00, MORE, 1);
      send_beat(8'hFF, MORE, 1);           send_beat(CHAR_TAB, MORE, 1);
      send_beat(CHAR_CR, MORE, 1);         send_beat(CHAR_LF, MORE, 1);
      send_beat(CHAR_BACKSLASH, MORE, 1);  send_beat(CHAR_LF, MORE, 1);
      send_beat(CHAR_BACKSLASH, MORE, 1);  send_beat(CHAR_CR, MORE, 1);
      send_beat(CHAR_LF, MORE, 1);
      send_beat(CHAR_BACKSLASH, MORE, 1);  send_beat(8'h78, MORE, 1);
      send_beat(CHAR_BACKSLASH, MORE, 1);  send_beat(CHAR_BACKSLASH, MORE, 1);
      // The end mark flushes the backslash still held.
      send_beat(8'hFF, END_OF_STREAM, 1);
      // CR followed by another byte, then a byte that must be ignored.
      send_beat(CHAR_CR, MORE, 1);         send_beat(8'h71, MORE, 1);
      send_beat(8'h7A, MORE, 0);           send_beat(8'h00, END_OF_STREAM, 1);
      // Stream ending while the LF of a backslash-CR is still due.
      send_beat(CHAR_BACKSLASH, MORE, 1);  send_beat(CHAR_CR, MORE, 1);
      send_beat(8'h55, END_OF_STREAM, 1);
      // Empty stream, then a backslash-CR broken by an ordinary byte.
      send_beat(8'hAA, END_OF_STREAM, 1);
      send_beat(CHAR_BACKSLASH, MORE, 1);  send_beat(CHAR_CR, MORE, 1);
      send_beat(8'h79, MORE, 1);           send_beat(8'h00, END_OF_STREAM, 1);
      wait_drained();

      while (items_sent < ITEM_TARGET) begin
         if (items_sent > ITEM_TARGET - CALM_ITEMS) calm = 1'b1;
         send_stream();
         if ($urandom_range(0, 11) == 0) wait_drained();
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d beats over %0d random streams plus the opening cases;",
               items_sent, streams_done);
      $display("%0d streams ended broken, %0d result beats checked.", broken_ends, checked);
      if (mismatches == 0 && pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
